// File: src/ssc_pkg.sv
// Shared constants, stage word types and helpers for the sphere contact pipeline.
package ssc_pkg;

  // One root bit per square-root stage; the contact quotient uses the same stages.
  localparam int SqrtSteps   = 32;
  // Quotient bits of a normal component; its magnitude never exceeds 2^30.
  localparam int NormSteps   = 31;
  localparam int FrontStages = 6;
  localparam int BackStages  = 3;
  localparam int Latency     = FrontStages + SqrtSteps + 1 + NormSteps + BackStages;

  localparam logic [30:0]        RadiusMax = 31'h7FFF_FFFF;
  localparam logic signed [31:0] OneQ30    = 32'sh4000_0000;

  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][31:0]  mag;
    logic [31:0]       thr;
    logic [2:0][62:0]  prod;
    logic [2:0][31:0]  ca;
  } front_carry_t;

  typedef struct packed {
    logic              hit;
    logic              zero;
    logic [63:0]       dist_sq;
    logic [32:0]       rem;
    logic [31:0]       root;
    logic [2:0]        neg;
    logic [2:0][31:0]  mag;
    logic [31:0]       thr;
    logic [2:0][62:0]  prod;
    logic [2:0][31:0]  crem;
    logic [2:0][31:0]  cq;
    logic [2:0][31:0]  ca;
  } sqrt_stage_t;

  typedef struct packed {
    logic              hit;
    logic              zero;
    logic [2:0]        neg;
    logic [2:0]        mag_lsb;
    logic [31:0]       divisor;
    logic [2:0][31:0]  nrem;
    logic [2:0][30:0]  nq;
    logic [2:0][31:0]  con;
  } norm_stage_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/sphere_sphere_contact_core.sv
// Sphere-sphere contact test: fully pipelined Q16.16 datapath (normals scaled by 2^30) with sqrt and dividers.
// A word accepted on start_i reaches the result ports through, in order,
// 6 front stages, 32 square-root stages that also form the contact quotient,
// 1 setup stage, 31 normal-divider stages, 3 dot-product and output stages.
// Throughput: one word per cycle; busy_o stays low and the receiver cannot stall.
// Reset clears every stage valid bit and valid_o; datapath registers are not reset.
module sphere_sphere_contact_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [30:0]        radius_a_i,
  input  logic [30:0]        scale_a_i,
  input  logic signed [31:0] center_a_x_i,
  input  logic signed [31:0] center_a_y_i,
  input  logic signed [31:0] center_a_z_i,
  input  logic [30:0]        radius_b_i,
  input  logic [30:0]        scale_b_i,
  input  logic signed [31:0] center_b_x_i,
  input  logic signed [31:0] center_b_y_i,
  input  logic signed [31:0] center_b_z_i,
  output logic               valid_o,
  output logic               hit_o,
  output logic signed [31:0] normal_x_o,
  output logic signed [31:0] normal_y_o,
  output logic signed [31:0] normal_z_o,
  output logic signed [31:0] contact_x_o,
  output logic signed [31:0] contact_y_o,
  output logic signed [31:0] contact_z_o,
  output logic signed [31:0] plane_offset_o
);
  import ssc_pkg::*;

  logic signed [31:0] ca_in [3];
  logic signed [31:0] cb_in [3];
  logic               accept;

  assign busy_o   = 1'b0;
  assign accept   = start_i & ~busy_o;
  assign ca_in[0] = center_a_x_i;
  assign ca_in[1] = center_a_y_i;
  assign ca_in[2] = center_a_z_i;
  assign cb_in[0] = center_b_x_i;
  assign cb_in[1] = center_b_y_i;
  assign cb_in[2] = center_b_z_i;

  // Front stages.
  logic               f1_v_q, f2_v_q, f3_v_q, f4_v_q, f5_v_q;
  logic [61:0]        f1_pa_q, f1_pb_q;
  logic signed [32:0] f1_diff_q [3];
  logic [31:0]        f1_ca_q [3];
  logic [30:0]        f2_ra_q;
  logic [31:0]        f2_thr_q;
  logic [2:0]         f2_neg_q;
  logic [31:0]        f2_mag_q [3];
  logic [31:0]        f2_ca_q [3];
  logic [63:0]        f3_sq_q [3];
  logic [63:0]        f3_thr_sq_q;
  front_carry_t       f3_c_q;
  logic [64:0]        f4_s01_q;
  logic [63:0]        f4_sq2_q;
  logic [63:0]        f4_thr_sq_q;
  front_carry_t       f4_c_q;
  logic [63:0]        f5_dist_sq_q;
  logic [63:0]        f5_thr_sq_q;
  front_carry_t       f5_c_q;
  logic [65:0]        f5_sum;

  assign f5_sum = 66'(f4_s01_q) + 66'(f4_sq2_q);

  always_ff @(posedge clk_i) begin
    f1_pa_q <= 62'(radius_a_i) * 62'(scale_a_i);
    f1_pb_q <= 62'(radius_b_i) * 62'(scale_b_i);
    for (int c = 0; c < 3; c++) begin
      f1_diff_q[c] <= 33'(cb_in[c]) - 33'(ca_in[c]);
      f1_ca_q[c]   <= ca_in[c];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [30:0] ra, rb;
    logic [32:0] neg_diff;
    ra = (|f1_pa_q[61:47]) ? RadiusMax : f1_pa_q[46:16];
    rb = (|f1_pb_q[61:47]) ? RadiusMax : f1_pb_q[46:16];
    f2_ra_q  <= ra;
    f2_thr_q <= {1'b0, ra} + {1'b0, rb};
    for (int c = 0; c < 3; c++) begin
      neg_diff     = ~f1_diff_q[c] + 33'd1;
      f2_neg_q[c] <= f1_diff_q[c][32];
      f2_mag_q[c] <= f1_diff_q[c][32] ? neg_diff[31:0] : f1_diff_q[c][31:0];
      f2_ca_q[c]  <= f1_ca_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    f3_thr_sq_q <= 64'(f2_thr_q) * 64'(f2_thr_q);
    f3_c_q.neg  <= f2_neg_q;
    f3_c_q.thr  <= f2_thr_q;
    for (int c = 0; c < 3; c++) begin
      f3_sq_q[c]     <= 64'(f2_mag_q[c]) * 64'(f2_mag_q[c]);
      f3_c_q.prod[c] <= 63'(f2_mag_q[c]) * 63'(f2_ra_q);
      f3_c_q.mag[c]  <= f2_mag_q[c];
      f3_c_q.ca[c]   <= f2_ca_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    f4_s01_q    <= 65'(f3_sq_q[0]) + 65'(f3_sq_q[1]);
    f4_sq2_q    <= f3_sq_q[2];
    f4_thr_sq_q <= f3_thr_sq_q;
    f4_c_q      <= f3_c_q;
  end

  // The squared distance saturates; a saturated sum is always beyond any threshold.
  always_ff @(posedge clk_i) begin
    f5_dist_sq_q <= (|f5_sum[65:64]) ? {64{1'b1}} : f5_sum[63:0];
    f5_thr_sq_q  <= f4_thr_sq_q;
    f5_c_q       <= f4_c_q;
  end

  // Square-root pipeline; the contact quotient runs alongside it.
  sqrt_stage_t b_q  [SqrtSteps+1];
  logic        bv_q [SqrtSteps+1];

  always_ff @(posedge clk_i) begin
    b_q[0].hit     <= (f5_c_q.thr != 32'd0) && (f5_dist_sq_q <= f5_thr_sq_q);
    b_q[0].zero    <= (f5_dist_sq_q == 64'd0);
    b_q[0].dist_sq <= f5_dist_sq_q;
    b_q[0].rem     <= '0;
    b_q[0].root    <= '0;
    b_q[0].neg     <= f5_c_q.neg;
    b_q[0].mag     <= f5_c_q.mag;
    b_q[0].thr     <= f5_c_q.thr;
    b_q[0].prod    <= f5_c_q.prod;
    b_q[0].ca      <= f5_c_q.ca;
    b_q[0].cq      <= '0;
    for (int c = 0; c < 3; c++) begin
      b_q[0].crem[c] <= {1'b0, f5_c_q.prod[c][62:32]};
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam int Bit = SqrtSteps - 1 - k;
    sqrt_stage_t b_d;
    logic [34:0] s_t;
    logic [34:0] trial;
    logic [32:0] ct [3];

    always_comb begin
      b_d   = b_q[k];
      s_t   = {b_q[k].rem, b_q[k].dist_sq[2*Bit+1 -: 2]};
      trial = {1'b0, b_q[k].root, 2'b01};
      if (s_t >= trial) begin
        b_d.rem  = 33'(s_t - trial);
        b_d.root = {b_q[k].root[30:0], 1'b1};
      end else begin
        b_d.rem  = s_t[32:0];
        b_d.root = {b_q[k].root[30:0], 1'b0};
      end
      for (int c = 0; c < 3; c++) begin
        ct[c] = {b_q[k].crem[c], b_q[k].prod[c][Bit]};
        if (ct[c] >= {1'b0, b_q[k].thr}) begin
          b_d.crem[c] = 32'(ct[c] - {1'b0, b_q[k].thr});
          b_d.cq[c]   = {b_q[k].cq[c][30:0], 1'b1};
        end else begin
          b_d.crem[c] = ct[c][31:0];
          b_d.cq[c]   = {b_q[k].cq[c][30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      b_q[k+1] <= b_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bv_q[k+1] <= 1'b0;
      end else begin
        bv_q[k+1] <= bv_q[k];
      end
    end
  end

  // Normal divider pipeline; the finished contact point rides along.
  norm_stage_t n_q  [NormSteps+1];
  logic        nv_q [NormSteps+1];

  always_ff @(posedge clk_i) begin
    logic signed [33:0] q;
    n_q[0].hit     <= b_q[SqrtSteps].hit;
    n_q[0].zero    <= b_q[SqrtSteps].zero;
    n_q[0].neg     <= b_q[SqrtSteps].neg;
    n_q[0].divisor <= b_q[SqrtSteps].root;
    n_q[0].nq      <= '0;
    for (int c = 0; c < 3; c++) begin
      q = $signed({2'b00, b_q[SqrtSteps].cq[c]});
      if (b_q[SqrtSteps].neg[c]) begin
        q = -q;
      end
      n_q[0].con[c]     <= sat32(34'($signed(b_q[SqrtSteps].ca[c])) + q);
      n_q[0].nrem[c]    <= {1'b0, b_q[SqrtSteps].mag[c][31:1]};
      n_q[0].mag_lsb[c] <= b_q[SqrtSteps].mag[c][0];
    end
  end

  for (genvar j = 0; j < NormSteps; j++) begin : g_norm
    norm_stage_t n_d;
    logic [32:0] t [3];

    always_comb begin
      n_d = n_q[j];
      for (int c = 0; c < 3; c++) begin
        // Only the first step shifts in a dividend bit; the rest are zeros.
        t[c] = {n_q[j].nrem[c], (j == 0) ? n_q[j].mag_lsb[c] : 1'b0};
        if (t[c] >= {1'b0, n_q[j].divisor}) begin
          n_d.nrem[c] = 32'(t[c] - {1'b0, n_q[j].divisor});
          n_d.nq[c]   = {n_q[j].nq[c][29:0], 1'b1};
        end else begin
          n_d.nrem[c] = t[c][31:0];
          n_d.nq[c]   = {n_q[j].nq[c][29:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[j+1] <= n_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[j+1] <= 1'b0;
      end else begin
        nv_q[j+1] <= nv_q[j];
      end
    end
  end

  // Back stages: normal sign and coincident case, products, dot sum.
  logic               d1_hit_q, d2_hit_q;
  logic signed [31:0] d1_nrm_q [3];
  logic signed [31:0] d1_con_q [3];
  logic signed [31:0] d2_nrm_q [3];
  logic signed [31:0] d2_con_q [3];
  logic signed [63:0] d2_prod_q [3];
  logic               d1_v_q, d2_v_q, out_v_q;
  logic               out_hit_q;
  logic signed [31:0] out_nrm_q [3];
  logic signed [31:0] out_con_q [3];
  logic signed [31:0] out_ofs_q;
  logic signed [65:0] dot_sum;
  logic signed [65:0] dot_shr;

  assign dot_sum = 66'(d2_prod_q[0]) + 66'(d2_prod_q[1]) + 66'(d2_prod_q[2]);
  assign dot_shr = dot_sum >>> 30;

  always_ff @(posedge clk_i) begin
    logic signed [31:0] mag_q;
    d1_hit_q <= n_q[NormSteps].hit;
    for (int c = 0; c < 3; c++) begin
      mag_q = $signed({1'b0, n_q[NormSteps].nq[c]});
      if (n_q[NormSteps].zero) begin
        d1_nrm_q[c] <= (c == 1) ? OneQ30 : 32'sd0;
      end else begin
        d1_nrm_q[c] <= n_q[NormSteps].neg[c] ? -mag_q : mag_q;
      end
      d1_con_q[c] <= $signed(n_q[NormSteps].con[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    d2_hit_q <= d1_hit_q;
    for (int c = 0; c < 3; c++) begin
      d2_prod_q[c] <= 64'(d1_nrm_q[c]) * 64'(d1_con_q[c]);
      d2_nrm_q[c]  <= d1_nrm_q[c];
      d2_con_q[c]  <= d1_con_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q <= d2_hit_q;
    out_ofs_q <= d2_hit_q ? sat32(dot_shr[33:0]) : 32'sd0;
    for (int c = 0; c < 3; c++) begin
      out_nrm_q[c] <= d2_hit_q ? d2_nrm_q[c] : 32'sd0;
      out_con_q[c] <= d2_hit_q ? d2_con_q[c] : 32'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q   <= 1'b0;
      f2_v_q   <= 1'b0;
      f3_v_q   <= 1'b0;
      f4_v_q   <= 1'b0;
      f5_v_q   <= 1'b0;
      bv_q[0]  <= 1'b0;
      nv_q[0]  <= 1'b0;
      d1_v_q   <= 1'b0;
      d2_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      f1_v_q   <= accept;
      f2_v_q   <= f1_v_q;
      f3_v_q   <= f2_v_q;
      f4_v_q   <= f3_v_q;
      f5_v_q   <= f4_v_q;
      bv_q[0]  <= f5_v_q;
      nv_q[0]  <= bv_q[SqrtSteps];
      d1_v_q   <= nv_q[NormSteps];
      d2_v_q   <= d1_v_q;
      out_v_q  <= d2_v_q;
    end
  end

  assign valid_o        = out_v_q;
  assign hit_o          = out_hit_q;
  assign normal_x_o     = out_nrm_q[0];
  assign normal_y_o     = out_nrm_q[1];
  assign normal_z_o     = out_nrm_q[2];
  assign contact_x_o    = out_con_q[0];
  assign contact_y_o    = out_con_q[1];
  assign contact_z_o    = out_con_q[2];
  assign plane_offset_o = out_ofs_q;

  // A miss carries nothing but the cleared fields.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !hit_o |-> normal_x_o == 32'sd0 && normal_y_o == 32'sd0 &&
      normal_z_o == 32'sd0 && contact_x_o == 32'sd0 && plane_offset_o == 32'sd0)
    else $error("miss word carries nonzero fields");

  // Normal components never leave the unit range.
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && hit_o |-> normal_x_o <= OneQ30 && normal_x_o >= -OneQ30 &&
      normal_y_o <= OneQ30 && normal_y_o >= -OneQ30 &&
      normal_z_o <= OneQ30 && normal_z_o >= -OneQ30)
    else $error("normal component out of range");

  // Words neither vanish nor appear inside the square-root pipeline, once the
  // pipeline has been out of reset for its full depth.
  a_sqrt_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, SqrtSteps) |-> bv_q[SqrtSteps] == $past(bv_q[0], SqrtSteps))
    else $error("valid lost or created in square-root stages");

endmodule
